>>> rtl/eewvs_pkg.sv
// shared types and codes for the eeprom write/verify sequencer
package eewvs_pkg;

    localparam logic [1:0] ACT_LOAD     = 2'd0;
    localparam logic [1:0] ACT_START    = 2'd1;
    localparam logic [1:0] ACT_BUS_DONE = 2'd2;
    localparam logic [1:0] ACT_TICK     = 2'd3;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [6:0] DEV_BASE   = 7'h50;
    localparam logic [7:0] WAIT_RESET = 8'd6;

    localparam logic CFG_DEVICE_SELECT = 1'b0;
    localparam logic CFG_WRITE_WAIT    = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] mem_addr;
        logic [7:0]  byte_count;
        logic [7:0]  load_index;
        logic [7:0]  data_byte;
        logic        bus_error;
        logic [7:0]  read_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  bus_command;
        logic [7:0]  device_addr;
        logic [15:0] cmd_mem_addr;
        logic [7:0]  cmd_data;
        logic        write_protect;
        logic [1:0]  status;
    } result_t;

endpackage

>>> rtl/eeprom_write_verify_sequencer_top.sv
// Serial EEPROM byte-write sequencer with read-back verify.
// Requests arrive on the s_ valid/ready channel: load a byte into the store,
// start a write run, report a finished bus transfer, or a millisecond tick.
// Each accepted request gives exactly one result on the m_ channel carrying
// the bus command to issue (none, write, read), the device and memory
// address, the data byte, the write-protect level and the run status.
// The configuration port (cfg_wr_en, cfg_index, cfg_wdata) sets the device
// select pins and the wait in ticks after each write; write it while idle.
// A request is held in the input register, is evaluated and lands in the
// output register, from which the m_ channel takes its result. Throughput:
// one request per cycle while m_ready stays high, set by the single
// input-to-result register pass.
// The output register parts the channels: a new request is taken whenever
// the input register is empty or moves on; when m_ready is low the result
// holds and the input register fills, after which s_ready drops.
// Reset (aresetn low, synchronous) returns to idle with write protect high,
// wait 6, select 0 and both channels empty. Store contents are not cleared.
module eeprom_write_verify_sequencer_top #(
    parameter int STORE_DEPTH = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  eewvs_pkg::item_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output eewvs_pkg::result_t m_data,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_wdata
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(STORE_DEPTH - 1);

    typedef logic [AW-1:0] slot_tbl_t [256];

    function automatic slot_tbl_t build_slot_tbl();
        slot_tbl_t tbl;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = AW'(i % STORE_DEPTH);
        end
        return tbl;
    endfunction

    localparam slot_tbl_t SLOT_TBL = build_slot_tbl();

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WRITE,
        PH_WAIT,
        PH_READ
    } phase_t;

    logic [2:0]         device_select_reg;
    logic [7:0]         write_wait_reg;
    phase_t             phase_reg, phase_next;
    logic [7:0]         byte_index_reg, byte_index_next;
    logic [AW-1:0]      slot_reg, slot_next;
    logic [7:0]         total_reg, total_next;
    logic [15:0]        base_reg, base_next;
    logic [7:0]         elapsed_reg, elapsed_next;
    logic               protect_reg, protect_next;
    logic [7:0]         cur_byte_reg, cur_byte_next;
    logic [7:0]         slot0_reg, slot0_next;

    logic               in_valid_reg;
    eewvs_pkg::item_t   in_item_reg;
    logic               m_valid_reg;
    eewvs_pkg::result_t m_data_reg;
    eewvs_pkg::result_t res;

    logic               proc;
    logic               mem_we;
    logic [AW-1:0]      load_slot;
    logic [AW-1:0]      slot_inc;
    logic [7:0]         next_byte;
    logic [7:0]         bi_inc;
    logic [7:0]         el_inc;

    assign proc    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign load_slot = SLOT_TBL[in_item_reg.load_index];
    assign slot_inc  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + AW'(1);
    assign bi_inc    = byte_index_reg + 8'd1;
    assign el_inc    = (elapsed_reg == 8'hFF) ? elapsed_reg : elapsed_reg + 8'd1;

    // prefetches the byte after the current one while the write and wait run
    eewvs_byte_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_we),
        .wr_addr (load_slot),
        .wr_data (in_item_reg.data_byte),
        .rd_addr (slot_inc),
        .rd_data (next_byte)
    );

    always_comb begin
        phase_next      = phase_reg;
        byte_index_next = byte_index_reg;
        slot_next       = slot_reg;
        total_next      = total_reg;
        base_next       = base_reg;
        elapsed_next    = elapsed_reg;
        protect_next    = protect_reg;
        cur_byte_next   = cur_byte_reg;
        slot0_next      = slot0_reg;
        mem_we          = 1'b0;
        res             = '0;
        res.device_addr = {eewvs_pkg::DEV_BASE[6:3], device_select_reg, 1'b0};
        res.bus_command = eewvs_pkg::CMD_NONE;
        res.status      = eewvs_pkg::ST_BUSY;

        if (proc) begin
            case (in_item_reg.action)
                eewvs_pkg::ACT_LOAD: begin
                    mem_we = 1'b1;
                    if (load_slot == slot_reg) begin
                        cur_byte_next = in_item_reg.data_byte;
                    end
                    if (load_slot == '0) begin
                        slot0_next = in_item_reg.data_byte;
                    end
                end
                eewvs_pkg::ACT_START: begin
                    if (phase_reg == PH_IDLE) begin
                        byte_index_next  = 8'd0;
                        slot_next        = '0;
                        total_next       = in_item_reg.byte_count;
                        base_next        = in_item_reg.mem_addr;
                        elapsed_next     = 8'd0;
                        protect_next     = 1'b0;
                        phase_next       = PH_WRITE;
                        cur_byte_next    = slot0_reg;
                        res.bus_command  = eewvs_pkg::CMD_WRITE;
                        res.cmd_mem_addr = in_item_reg.mem_addr;
                        res.cmd_data     = slot0_reg;
                    end
                end
                eewvs_pkg::ACT_BUS_DONE: begin
                    if (phase_reg == PH_WRITE) begin
                        if (in_item_reg.bus_error) begin
                            phase_next   = PH_IDLE;
                            protect_next = 1'b1;
                            res.status   = eewvs_pkg::ST_ERR;
                        end else begin
                            elapsed_next = 8'd0;
                            phase_next   = PH_WAIT;
                        end
                    end else if (phase_reg == PH_READ) begin
                        if (in_item_reg.bus_error ||
                            (in_item_reg.read_byte != cur_byte_reg)) begin
                            phase_next   = PH_IDLE;
                            protect_next = 1'b1;
                            res.status   = eewvs_pkg::ST_ERR;
                        end else begin
                            byte_index_next = bi_inc;
                            slot_next       = slot_inc;
                            if (bi_inc < total_reg) begin
                                phase_next       = PH_WRITE;
                                cur_byte_next    = next_byte;
                                res.bus_command  = eewvs_pkg::CMD_WRITE;
                                res.cmd_mem_addr = base_reg + {8'd0, bi_inc};
                                res.cmd_data     = next_byte;
                            end else begin
                                phase_next   = PH_IDLE;
                                protect_next = 1'b1;
                                res.status   = eewvs_pkg::ST_OK;
                            end
                        end
                    end
                end
                eewvs_pkg::ACT_TICK: begin
                    if (phase_reg == PH_WAIT) begin
                        elapsed_next = el_inc;
                        if (el_inc >= write_wait_reg) begin
                            phase_next       = PH_READ;
                            res.bus_command  = eewvs_pkg::CMD_READ;
                            res.cmd_mem_addr = base_reg + {8'd0, byte_index_reg};
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        res.write_protect = protect_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_select_reg <= 3'd0;
            write_wait_reg    <= eewvs_pkg::WAIT_RESET;
            phase_reg         <= PH_IDLE;
            byte_index_reg    <= 8'd0;
            slot_reg          <= '0;
            total_reg         <= 8'd0;
            base_reg          <= 16'd0;
            elapsed_reg       <= 8'd0;
            protect_reg       <= 1'b1;
            in_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    eewvs_pkg::CFG_DEVICE_SELECT: device_select_reg <= cfg_wdata[2:0];
                    eewvs_pkg::CFG_WRITE_WAIT:    write_wait_reg    <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            phase_reg      <= phase_next;
            byte_index_reg <= byte_index_next;
            slot_reg       <= slot_next;
            total_reg      <= total_next;
            base_reg       <= base_next;
            elapsed_reg    <= elapsed_next;
            protect_reg    <= protect_next;
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (proc) begin
                in_valid_reg <= 1'b0;
            end
            if (proc) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cur_byte_reg <= cur_byte_next;
        slot0_reg    <= slot0_next;
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (proc) begin
            m_data_reg <= res;
        end
    end

endmodule

>>> rtl/eewvs_byte_store.sv
// byte store memory with one write port and one registered read port
module eewvs_byte_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr_reg;
    logic          wr_last_reg;
    logic [AW-1:0] wr_addr_reg;
    logic [7:0]    wr_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_addr_reg <= rd_addr;
        wr_addr_reg <= wr_addr;
        wr_data_reg <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_last_reg <= 1'b0;
        end else begin
            wr_last_reg <= wr_en;
        end
    end

    // a write in the read cycle returned old data, take the written byte instead
    assign rd_data = (wr_last_reg && (wr_addr_reg == rd_addr_reg)) ? wr_data_reg
                                                                  : rd_data_reg;

endmodule
